/* hdl/mi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mi_pkg: shared constants and types for the modular inverse unit
// Widths, step counts, datapath command codes, command and status structs.
// ---------------------------------------------------------------------------
package mi_pkg;

   localparam int OPERAND_BITS = 256;
   localparam int WORD_BITS    = 64;
   localparam int NWORDS       = (OPERAND_BITS + WORD_BITS - 1) / WORD_BITS;
   // working width: one spare 64-bit limb above the operand
   localparam int BIG_BITS     = ((OPERAND_BITS + 63) / 64 + 1) * 64;
   localparam int DIV_STEPS    = 4 + 3 * OPERAND_BITS;
   localparam int CNT_W        = $clog2(DIV_STEPS + 1);
   localparam int E_W          = $clog2(OPERAND_BITS + 1);
   localparam int IDX_W        = 2;
   localparam int DELTA_W      = 16;

   // request kinds
   localparam logic [1:0] KIND_LOAD_A = 2'd0;
   localparam logic [1:0] KIND_LOAD_N = 2'd1;
   localparam logic [1:0] KIND_START  = 2'd2;

   // datapath commands
   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD_A   = 5'd1;
   localparam logic [OP_W-1:0] OP_LOAD_N   = 5'd2;
   localparam logic [OP_W-1:0] OP_INIT     = 5'd3;
   localparam logic [OP_W-1:0] OP_TZ       = 5'd4;
   localparam logic [OP_W-1:0] OP_DIV_INIT = 5'd5;
   localparam logic [OP_W-1:0] OP_DIV      = 5'd6;
   localparam logic [OP_W-1:0] OP_DIV_FIN  = 5'd7;
   localparam logic [OP_W-1:0] OP_MOD      = 5'd8;
   localparam logic [OP_W-1:0] OP_MOD_FIN  = 5'd9;
   localparam logic [OP_W-1:0] OP_P2A_INIT = 5'd10;
   localparam logic [OP_W-1:0] OP_P2M_INIT = 5'd11;
   localparam logic [OP_W-1:0] OP_P2       = 5'd12;
   localparam logic [OP_W-1:0] OP_SAVE     = 5'd13;
   localparam logic [OP_W-1:0] OP_SUB      = 5'd14;
   localparam logic [OP_W-1:0] OP_MUL1_INI = 5'd15;
   localparam logic [OP_W-1:0] OP_MUL2_INI = 5'd16;
   localparam logic [OP_W-1:0] OP_MUL      = 5'd17;
   localparam logic [OP_W-1:0] OP_CRT_FIN  = 5'd18;
   localparam logic [OP_W-1:0] OP_NEG_ADJ  = 5'd19;
   localparam logic [OP_W-1:0] OP_FAIL     = 5'd20;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [CNT_W-1:0] cnt;
   } cmd_type;

   typedef struct packed {
      logic n_trivial;
      logic n_odd;
      logic m_odd;
      logic m_one;
      logic a_odd;
      logic inv_ok;
   } status_type;

endpackage
`default_nettype wire

/* hdl/mi_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mi_datapath: operand stores and wide working registers
// Runs divsteps, serial reduction, inversion mod 2^e and shift-add
// multiplies one step per command.
// ---------------------------------------------------------------------------
module mi_datapath (
   input  wire logic                 clock,
   input  wire mi_pkg::cmd_type      cmd,
   input  wire logic [1:0]           word_index,
   input  wire logic [63:0]          data_word,
   input  wire logic                 a_negative,
   output mi_pkg::status_type        status,
   output logic [63:0]               res_word,
   output logic                      none
);
   import mi_pkg::*;

   localparam int B = BIG_BITS;
   localparam int AW = $clog2(NWORDS);

   logic [WORD_BITS-1:0] store_a [NWORDS];
   logic [WORD_BITS-1:0] store_n [NWORDS];

   logic [B-1:0] a_ff, n_ff, m_ff, f_ff, g_ff, v_ff, r_ff, w1_ff, w2_ff, w3_ff, emask_ff;
   logic [B-1:0] a_in, n_in, m_in, f_in, g_in, v_in, r_in, w1_in, w2_in, w3_in, emask_in;
   logic [DELTA_W-1:0] delta_ff, delta_in;
   logic neg_ff, neg_in, sel_ff, sel_in, aneg_ff, aneg_in, none_ff, none_in;

   logic [B-1:0] big_a, big_n;
   logic         g0, cond;
   logic [B-1:0] gsum, vsel, addn, rsum;
   logic         fneg;
   logic [B-1:0] fabs, vn, rem2, adj, lo, p2t, neg_d;
   logic [B:0]   diff;

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD_A && 32'(word_index) < NWORDS)
         store_a[word_index[AW-1:0]] <= data_word[WORD_BITS-1:0];
      if (cmd.op == OP_LOAD_N && 32'(word_index) < NWORDS)
         store_n[word_index[AW-1:0]] <= data_word[WORD_BITS-1:0];
   end

   always_comb begin
      big_a = '0;
      big_n = '0;
      for (int i = 0; i < NWORDS; i++) begin
         big_a[i*WORD_BITS +: WORD_BITS] = store_a[i];
         big_n[i*WORD_BITS +: WORD_BITS] = store_n[i];
      end
   end

   // divstep terms
   assign g0   = g_ff[0];
   assign cond = g0 && !delta_ff[DELTA_W-1] && (delta_ff != '0);
   assign gsum = cond ? (g_ff - f_ff) : (g0 ? (g_ff + f_ff) : g_ff);
   assign vsel = g0 ? (cond ? (-v_ff) : v_ff) : '0;
   assign addn = (r_ff[0] ^ vsel[0]) ? m_ff : '0;
   assign rsum = r_ff + vsel + addn;

   // normalize sign of f and v after the divsteps
   assign fneg = f_ff[B-1];
   assign fabs = fneg ? (-f_ff) : f_ff;
   assign vn   = fneg ? (-v_ff) : v_ff;

   // restoring reduction step
   assign rem2 = {r_ff[B-2:0], g_ff[B-1]};
   assign diff = {1'b0, rem2} - {1'b0, m_ff};
   assign adj  = (neg_ff && r_ff != '0) ? (m_ff - r_ff) : r_ff;

   // inversion mod 2^e step
   assign lo   = (sel_ff ? m_ff : a_ff) & emask_ff;
   assign p2t  = w1_ff[0] ? (w1_ff - lo) : w1_ff;

   assign neg_d = n_ff - w1_ff;

   always_comb begin
      a_in = a_ff; n_in = n_ff; m_in = m_ff; f_in = f_ff; g_in = g_ff;
      v_in = v_ff; r_in = r_ff; w1_in = w1_ff; w2_in = w2_ff; w3_in = w3_ff;
      emask_in = emask_ff; delta_in = delta_ff; neg_in = neg_ff; sel_in = sel_ff;
      aneg_in = aneg_ff; none_in = none_ff;
      case (cmd.op)
         OP_INIT: begin
            a_in = big_a; n_in = big_n; m_in = big_n;
            emask_in = '0; aneg_in = a_negative; none_in = 1'b0;
         end
         OP_TZ: begin
            m_in = {1'b0, m_ff[B-1:1]};
            emask_in = {emask_ff[B-2:0], 1'b1};
         end
         OP_DIV_INIT: begin
            f_in = m_ff; g_in = a_ff; v_in = '0; r_in = B'(1);
            delta_in = DELTA_W'(1);
         end
         OP_DIV: begin
            if (cond) begin
               f_in = g_ff;
               v_in = r_ff;
               delta_in = DELTA_W'(1) - delta_ff;
            end else begin
               delta_in = delta_ff + DELTA_W'(1);
            end
            g_in = {gsum[B-1], gsum[B-1:1]};
            r_in = {rsum[B-1], rsum[B-1:1]};
         end
         OP_DIV_FIN: begin
            g_in = vn[B-1] ? (-vn) : vn;
            r_in = '0;
            neg_in = vn[B-1];
         end
         OP_MOD: begin
            r_in = diff[B] ? rem2 : diff[B-1:0];
            g_in = {g_ff[B-2:0], 1'b0};
         end
         OP_MOD_FIN: begin
            v_in = adj; w1_in = adj;
         end
         OP_P2A_INIT: begin
            w1_in = B'(1); w2_in = '0; sel_in = 1'b0;
         end
         OP_P2M_INIT: begin
            w1_in = B'(1); w2_in = '0; sel_in = 1'b1;
         end
         OP_P2: begin
            if (w1_ff[0]) w2_in = w2_ff | (B'(1) << cmd.cnt);
            w1_in = {p2t[B-1], p2t[B-1:1]};
         end
         OP_SAVE: begin
            w3_in = w2_ff; w1_in = w2_ff;
         end
         OP_SUB: begin
            w3_in = w3_ff - v_ff;
         end
         OP_MUL1_INI: begin
            w1_in = '0; g_in = w3_ff;
         end
         OP_MUL2_INI: begin
            w2_in = w1_ff & emask_ff; w1_in = '0; g_in = m_ff;
         end
         OP_MUL: begin
            if (w2_ff[0]) w1_in = w1_ff + g_ff;
            g_in = {g_ff[B-2:0], 1'b0};
            w2_in = {1'b0, w2_ff[B-1:1]};
         end
         OP_CRT_FIN: begin
            w1_in = w1_ff + v_ff;
         end
         OP_NEG_ADJ: begin
            if (aneg_ff && w1_ff != '0) w1_in = neg_d;
         end
         OP_FAIL: begin
            w1_in = '0; none_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; n_ff <= n_in; m_ff <= m_in; f_ff <= f_in; g_ff <= g_in;
      v_ff <= v_in; r_ff <= r_in; w1_ff <= w1_in; w2_ff <= w2_in; w3_ff <= w3_in;
      emask_ff <= emask_in; delta_ff <= delta_in; neg_ff <= neg_in; sel_ff <= sel_in;
      aneg_ff <= aneg_in; none_ff <= none_in;
   end

   assign status.n_trivial = (n_ff == '0) || (n_ff == B'(1));
   assign status.n_odd     = n_ff[0];
   assign status.m_odd     = m_ff[0];
   assign status.m_one     = (m_ff == B'(1));
   assign status.a_odd     = a_ff[0];
   assign status.inv_ok    = (fabs == B'(1));

   assign res_word = 64'(w1_ff[cmd.cnt[IDX_W-1:0]*WORD_BITS +: WORD_BITS]);
   assign none     = none_ff;

endmodule
`default_nettype wire

/* hdl/mi_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mi_controller: sequencer for the modular inverse unit
// Takes load and start transactions, steps the datapath through the
// selected inversion path and streams the result words.
// ---------------------------------------------------------------------------
module mi_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic [1:0]           req_kind,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_last,
   output logic [1:0]                rsp_index,
   input  wire mi_pkg::status_type   status,
   output mi_pkg::cmd_type           cmd
);
   import mi_pkg::*;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_CHECK = 5'd1;
   localparam logic [4:0] S_TZ    = 5'd2;
   localparam logic [4:0] S_TZCHK = 5'd3;
   localparam logic [4:0] S_DINIT = 5'd4;
   localparam logic [4:0] S_DIV   = 5'd5;
   localparam logic [4:0] S_DFIN  = 5'd6;
   localparam logic [4:0] S_MOD   = 5'd7;
   localparam logic [4:0] S_MFIN  = 5'd8;
   localparam logic [4:0] S_P2AI  = 5'd9;
   localparam logic [4:0] S_P2A   = 5'd10;
   localparam logic [4:0] S_SAVE  = 5'd11;
   localparam logic [4:0] S_P2MI  = 5'd12;
   localparam logic [4:0] S_P2M   = 5'd13;
   localparam logic [4:0] S_SUB   = 5'd14;
   localparam logic [4:0] S_M1I   = 5'd15;
   localparam logic [4:0] S_MUL1  = 5'd16;
   localparam logic [4:0] S_M2I   = 5'd17;
   localparam logic [4:0] S_MUL2  = 5'd18;
   localparam logic [4:0] S_CFIN  = 5'd19;
   localparam logic [4:0] S_NEG   = 5'd20;
   localparam logic [4:0] S_FAIL  = 5'd21;
   localparam logic [4:0] S_EMIT  = 5'd22;

   logic [4:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [E_W-1:0]   e_ff, e_in;
   logic             crt_ff, crt_in;
   logic             e_last, div_last, mod_last;

   assign e_last   = (cnt_ff == CNT_W'(e_ff) - CNT_W'(1));
   assign div_last = (cnt_ff == CNT_W'(DIV_STEPS - 1));
   assign mod_last = (cnt_ff == CNT_W'(BIG_BITS - 1));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + CNT_W'(1);
      e_in     = e_ff;
      crt_in   = crt_ff;
      cmd.op   = OP_NONE;
      cmd.cnt  = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               case (req_kind)
                  KIND_LOAD_A: cmd.op = OP_LOAD_A;
                  KIND_LOAD_N: cmd.op = OP_LOAD_N;
                  KIND_START: begin
                     cmd.op   = OP_INIT;
                     e_in     = '0;
                     state_in = S_CHECK;
                  end
                  default: cmd.op = OP_NONE;
               endcase
            end
         end
         S_CHECK: begin
            crt_in = 1'b0;
            if (status.n_trivial) state_in = S_FAIL;
            else if (status.n_odd) state_in = S_DINIT;
            else state_in = S_TZ;
         end
         S_TZ: begin
            // strip factors of two from the modulus
            if (status.m_odd) begin
               state_in = S_TZCHK;
            end else begin
               cmd.op = OP_TZ;
               e_in   = e_ff + E_W'(1);
            end
         end
         S_TZCHK: begin
            if (!status.a_odd) begin
               state_in = S_FAIL;
            end else if (status.m_one) begin
               state_in = S_P2AI;
            end else begin
               crt_in   = 1'b1;
               state_in = S_DINIT;
            end
         end
         S_DINIT: begin
            cmd.op   = OP_DIV_INIT;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV;
            if (div_last) state_in = S_DFIN;
         end
         S_DFIN: begin
            cmd.op = OP_DIV_FIN;
            cnt_in = '0;
            state_in = status.inv_ok ? S_MOD : S_FAIL;
         end
         S_MOD: begin
            cmd.op = OP_MOD;
            if (mod_last) state_in = S_MFIN;
         end
         S_MFIN: begin
            cmd.op   = OP_MOD_FIN;
            state_in = crt_ff ? S_P2AI : S_NEG;
         end
         S_P2AI: begin
            cmd.op   = OP_P2A_INIT;
            cnt_in   = '0;
            state_in = S_P2A;
         end
         S_P2A: begin
            cmd.op = OP_P2;
            if (e_last) state_in = S_SAVE;
         end
         S_SAVE: begin
            cmd.op   = OP_SAVE;
            state_in = crt_ff ? S_P2MI : S_NEG;
         end
         S_P2MI: begin
            cmd.op   = OP_P2M_INIT;
            cnt_in   = '0;
            state_in = S_P2M;
         end
         S_P2M: begin
            cmd.op = OP_P2;
            if (e_last) state_in = S_SUB;
         end
         S_SUB: begin
            cmd.op   = OP_SUB;
            state_in = S_M1I;
         end
         S_M1I: begin
            cmd.op   = OP_MUL1_INI;
            cnt_in   = '0;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            cmd.op = OP_MUL;
            if (e_last) state_in = S_M2I;
         end
         S_M2I: begin
            cmd.op   = OP_MUL2_INI;
            cnt_in   = '0;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.op = OP_MUL;
            if (e_last) state_in = S_CFIN;
         end
         S_CFIN: begin
            cmd.op   = OP_CRT_FIN;
            state_in = S_NEG;
         end
         S_NEG: begin
            cmd.op   = OP_NEG_ADJ;
            cnt_in   = '0;
            state_in = S_EMIT;
         end
         S_FAIL: begin
            cmd.op   = OP_FAIL;
            cnt_in   = '0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // hold the word until the transaction completes
            cnt_in = cnt_ff;
            if (rsp_ready) begin
               cnt_in = cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(NWORDS - 1)) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         e_ff     <= '0;
         crt_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         e_ff     <= e_in;
         crt_ff   <= crt_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_EMIT);
   assign rsp_last  = (cnt_ff == CNT_W'(NWORDS - 1));
   assign rsp_index = cnt_ff[IDX_W-1:0];

endmodule
`default_nettype wire

/* hdl/modular_inverse_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// modular_inverse_unit: inverse of a modulo n for 256-bit operands
// Load transactions are accepted while idle; a start transaction computes the
// inverse and returns it as four words.
// ---------------------------------------------------------------------------
// A start on odd n runs 772 divsteps and 320 reduction steps; n = 2^e inverts
// mod 2^e; other even n does both and joins them by CRT; then 4 output words.
// One item at a time: the next request is taken after the last result word.
// The divstep loop runs one step a cycle on a 320-bit adder.
// Synchronous reset returns the sequencer to idle; stores keep their data.
module modular_inverse_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,  // word_index[1:0], data_word[65:2], a_negative[66]
   input  wire logic [1:0]  req_tuser,  // kind[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,  // result_index[1:0], result_word[65:2]
   output logic             rsp_tuser,  // no_inverse
   output logic             rsp_tlast
);
   import mi_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic [63:0] res_word;
   logic [1:0]  res_index;

   mi_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_kind  (req_tuser),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_last  (rsp_tlast),
      .rsp_index (res_index),
      .status    (status),
      .cmd       (cmd)
   );

   mi_datapath u_dp (
      .clock      (clock),
      .cmd        (cmd),
      .word_index (req_tdata[1:0]),
      .data_word  (req_tdata[65:2]),
      .a_negative (req_tdata[66]),
      .status     (status),
      .res_word   (res_word),
      .none       (rsp_tuser)
   );

   assign rsp_tdata = {6'd0, res_word, res_index};

endmodule
`default_nettype wire

/* hdl/mi_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mi_checker: port-level assertions for the modular inverse unit
// Checks result stream behavior seen at the top-level ports.
// ---------------------------------------------------------------------------
module mi_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [71:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tlast
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // no new request while a result run is out
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken during result run");

   // run ends after the last word
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready)
      else $error("result run did not end");

   // no inverse reports zero words
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[65:2] == 64'd0)
      else $error("nonzero word with no inverse");

endmodule

bind modular_inverse_unit mi_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

/* dv/modular_inverse_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// modular_inverse_checker: scoreboard for the modular inverse unit
// Mirrors the operand and modulus stores from the request channel, predicts
// the four inverse words of every start and compares them in order with the
// response channel.
// ---------------------------------------------------------------------------
module modular_inverse_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [71:0] req_tdata,  // word_index[1:0], data_word[65:2], a_negative[66]
   input  wire logic [1:0]  req_tuser,  // kind[1:0]
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [71:0] rsp_tdata,  // result_index[1:0], result_word[65:2]
   input  wire logic        rsp_tuser,  // no_inverse
   input  wire logic        rsp_tlast,
   output int               fail_count,
   output int               pending
);
   import mi_pkg::*;

   typedef struct {
      logic [1:0]  index;
      logic [63:0] word;
      logic        none;
      logic        last;
   } inverse_word_type;

   inverse_word_type inverse_words_q[$];
   logic [63:0]   operand_words[NWORDS];
   logic [63:0]   modulus_words[NWORDS];

   initial fail_count = 0;
   assign pending = inverse_words_q.size();

   // Extended Euclid with the cofactor kept reduced mod n.
   function automatic void modular_inverse(input bit [255:0] a, input bit [255:0] n,
                                           input bit neg, output bit [255:0] x,
                                           output bit none);
      bit [511:0] r0, r1, t0, t1, q, tmp, nn;
      none = 1'b1;
      x    = '0;
      if (n > 1) begin
         nn = 512'(n);
         r0 = nn;
         r1 = 512'(a) % nn;
         t0 = '0;
         t1 = 512'(1);
         while (r1 != 0) begin
            q   = r0 / r1;
            tmp = r0 - q * r1;
            r0  = r1;
            r1  = tmp;
            tmp = (t0 + nn - (q * t1) % nn) % nn;
            t0  = t1;
            t1  = tmp;
         end
         if (r0 == 1) begin
            none = 1'b0;
            x    = t0[255:0];
            if (neg && x != 0) x = n - x;
         end
      end
   endfunction

   always @(posedge clock) begin
      bit [255:0]       a_val, n_val, x_val;
      bit               none;
      inverse_word_type exp_word;
      if (!reset && req_tvalid && req_tready) begin
         case (req_tuser)
            KIND_LOAD_A: operand_words[req_tdata[1:0]] = req_tdata[65:2];
            KIND_LOAD_N: modulus_words[req_tdata[1:0]] = req_tdata[65:2];
            KIND_START: begin
               for (int i = 0; i < NWORDS; i++) begin
                  a_val[i*64 +: 64] = operand_words[i];
                  n_val[i*64 +: 64] = modulus_words[i];
               end
               modular_inverse(a_val, n_val, req_tdata[66], x_val, none);
               for (int i = 0; i < NWORDS; i++) begin
                  exp_word.index = i[1:0];
                  exp_word.word  = x_val[i*64 +: 64];
                  exp_word.none  = none;
                  exp_word.last  = (i == NWORDS - 1);
                  inverse_words_q.push_back(exp_word);
               end
            end
            default: ;  // unused kind: no effect
         endcase
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (inverse_words_q.size() == 0) begin
            $display("%0t: unexpected response idx=%0d word=%h none=%b last=%b", $time,
                     rsp_tdata[1:0], rsp_tdata[65:2], rsp_tuser, rsp_tlast);
            fail_count++;
         end else begin
            exp_word = inverse_words_q.pop_front();
            if (rsp_tdata[1:0] !== exp_word.index) begin
               $display("%0t: result_index expected %0d actual %0d", $time,
                        exp_word.index, rsp_tdata[1:0]);
               fail_count++;
            end
            if (rsp_tdata[65:2] !== exp_word.word) begin
               $display("%0t: result_word expected %h actual %h", $time,
                        exp_word.word, rsp_tdata[65:2]);
               fail_count++;
            end
            if (rsp_tuser !== exp_word.none) begin
               $display("%0t: no_inverse expected %b actual %b", $time,
                        exp_word.none, rsp_tuser);
               fail_count++;
            end
            if (rsp_tlast !== exp_word.last) begin
               $display("%0t: last expected %b actual %b", $time, exp_word.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

endmodule

/* dv/tb_modular_inverse_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_modular_inverse_unit: stimulus and verdict for the modular inverse unit
// Directed corner cases, then random load/start sequences under three
// idle profiles, one long response stall and a drain pause.
// ---------------------------------------------------------------------------
module tb_modular_inverse_unit;
   import mi_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int         STALL_LIMIT = 20000;
   localparam int         HOLD_CYCLES = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   int fail_count;
   int pending;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int items_sent = 0;
   int hold_left = 0;
   bit hold_go = 1'b0;
   bit hold_done = 1'b0;
   int quiet_cycles = 0;

   always #1 clock = ~clock;

   modular_inverse_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   modular_inverse_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .fail_count(fail_count), .pending(pending)
   );

   // Response side: random backpressure plus one long hold-off.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_go && !hold_done) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_item(input logic [1:0] kind, input logic [1:0] idx,
                            input logic [63:0] data, input logic neg);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'b0, neg, data, idx};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic load_value(input logic [1:0] kind, input bit [255:0] value,
                             input bit [3:0] word_mask);
      for (int i = 0; i < NWORDS; i++)
         if (word_mask[i])
            send_item(kind, i[1:0], value[i*64 +: 64], 1'($urandom_range(1)));
   endtask

   function automatic bit [255:0] random_big();
      bit [255:0] v;
      for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
      case ($urandom_range(4))
         0: v = v >> $urandom_range(255);
         1: v = '1;
         2: v = {192'b0, v[63:0]};
         default: ;
      endcase
      return v;
   endfunction

   function automatic bit [255:0] random_modulus();
      bit [255:0] v;
      v = random_big();
      case ($urandom_range(9))
         0, 1, 2: v[0] = 1'b1;
         3:       v = 256'b1 << $urandom_range(1, 255);
         4, 5:    v = ((v >> $urandom_range(1, 200)) | 256'b1) << $urandom_range(1, 40);
         6:       v = 256'($urandom_range(1));
         7:       v = {224'b0, v[31:1], 1'b1};
         default: ;
      endcase
      return v;
   endfunction

   task automatic run_sequence();
      bit [255:0] a_val;
      bit [3:0]   a_mask;
      a_val  = random_big();
      if ($urandom_range(4) == 0) a_val[0] = 1'b0;
      a_mask = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'hF;
      load_value(KIND_LOAD_A, a_val, a_mask);
      if ($urandom_range(9) == 0) send_item(KIND_UNUSED, 2'($urandom_range(3)), {2{$urandom}}, 1'b0);
      if ($urandom_range(5) != 0) load_value(KIND_LOAD_N, random_modulus(), 4'hF);
      // occasionally leave the sequence without a start
      if ($urandom_range(9) != 0) send_item(KIND_START, 2'($urandom_range(3)),
                                            {2{$urandom}}, 1'($urandom_range(1)));
   endtask

   task automatic drain();
      // let the scoreboard see the last accepted transaction first
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corner cases
      send_idle_pct = 38;
      recv_idle_pct = 45;
      load_value(KIND_LOAD_A, 256'd3, 4'hF);
      load_value(KIND_LOAD_N, 256'd0, 4'hF);
      send_item(KIND_START, 2'd0, 64'd0, 1'b0);          // modulus zero
      send_item(KIND_LOAD_N, 2'd0, 64'd1, 1'b0);
      send_item(KIND_START, 2'd0, 64'd0, 1'b0);          // modulus one
      send_item(KIND_LOAD_N, 2'd0, 64'd7, 1'b0);
      send_item(KIND_START, 2'd0, 64'd0, 1'b0);          // odd modulus
      send_item(KIND_START, 2'd3, '1, 1'b1);             // negated operand
      send_item(KIND_LOAD_N, 2'd0, 64'd8, 1'b0);
      send_item(KIND_START, 2'd0, 64'd0, 1'b0);          // power of two
      send_item(KIND_LOAD_A, 2'd0, 64'd4, 1'b0);
      send_item(KIND_START, 2'd0, 64'd0, 1'b0);          // even a, power of two
      send_item(KIND_LOAD_N, 2'd0, 64'd12, 1'b0);
      send_item(KIND_LOAD_A, 2'd0, 64'd5, 1'b0);
      send_item(KIND_START, 2'd0, 64'd0, 1'b1);          // composite even modulus
      send_item(KIND_LOAD_A, 2'd0, 64'd3, 1'b0);
      send_item(KIND_START, 2'd0, 64'd0, 1'b0);          // gcd not one
      send_item(KIND_LOAD_A, 2'd0, 64'd0, 1'b0);
      send_item(KIND_START, 2'd0, 64'd0, 1'b1);          // negative zero
      send_item(KIND_UNUSED, 2'd2, '1, 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 45 : 0;
         recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 38 : 0;
         if (phase == 1) hold_go = 1'b1;
         while (items_sent < 82 * (phase + 1) + 24) run_sequence();
         req_tvalid <= 1'b0;
         // hold the sender until the block has drained
         drain();
         @(posedge clock);
      end

      drain();
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* files.f */
hdl/mi_pkg.sv
hdl/mi_datapath.sv
hdl/mi_controller.sv
hdl/modular_inverse_unit.sv
hdl/mi_checker.sv
dv/modular_inverse_checker.sv
dv/tb_modular_inverse_unit.sv
